// ----- src/assembly_source_tokenizer_macros.svh -----
// Assertion macros for the assembly source tokenizer.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASMTOK_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("asmtok: same-cycle check failed");

// Next-cycle implication.
`define ASMTOK_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("asmtok: next-cycle check failed");

`else

`define ASMTOK_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASMTOK_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- src/asmtok_pkg.sv -----
`default_nettype none

package asmtok_pkg;

   localparam int unsigned DEFAULT_POSITION_WIDTH = 16;
   localparam int unsigned FIELD_WIDTH            = 16;
   localparam int unsigned BYTE_WIDTH             = 8;
   localparam int unsigned KIND_WIDTH             = 3;
   localparam int unsigned QUEUE_DEPTH            = 4;

   // Characters the scanner looks for
   localparam logic [BYTE_WIDTH-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_VTAB    = 8'h0B;
   localparam logic [BYTE_WIDTH-1:0] CH_FORMFD  = 8'h0C;
   localparam logic [BYTE_WIDTH-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CH_DOT     = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CH_COLON   = 8'h3A;
   localparam logic [BYTE_WIDTH-1:0] CH_SEMI    = 8'h3B;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_A    = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_F    = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_X    = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_Z    = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CH_UNDER   = 8'h5F;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_A    = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_F    = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_X    = 8'h78;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_Z    = 8'h7A;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_COMMENT   = 3'd1,
      MODE_DIRECTIVE = 3'd2,
      MODE_ZERO      = 3'd3,
      MODE_DECIMAL   = 3'd4,
      MODE_HEX       = 3'd5,
      MODE_IDENT     = 3'd6
   } scan_mode_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      TK_NEWLINE   = 3'd0,
      TK_COMMA     = 3'd1,
      TK_COLON     = 3'd2,
      TK_DIRECTIVE = 3'd3,
      TK_NUMBER    = 3'd4,
      TK_IDENT     = 3'd5,
      TK_UNKNOWN   = 3'd6,
      TK_EOF       = 3'd7
   } token_kind_type;

   typedef struct packed {
      token_kind_type         token_kind;
      logic [FIELD_WIDTH-1:0] start_offset;
      logic [FIELD_WIDTH-1:0] token_length;
      logic [FIELD_WIDTH-1:0] token_line;
      logic [FIELD_WIDTH-1:0] token_column;
      logic                   last_of_run;
   } asmtok_result_type;

   // Up to two tokens come out of one byte: a flushed pending token, then a new one
   typedef struct packed {
      logic              first_valid;
      logic              second_valid;
      asmtok_result_type first;
      asmtok_result_type second;
   } asmtok_emit_type;

   function automatic logic is_digit(input logic [BYTE_WIDTH-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [BYTE_WIDTH-1:0] c);
      return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   function automatic logic is_xdigit(input logic [BYTE_WIDTH-1:0] c);
      return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F))
         || ((c >= CH_UP_A) && (c <= CH_UP_F));
   endfunction

   function automatic logic is_word(input logic [BYTE_WIDTH-1:0] c);
      return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
   endfunction

   function automatic logic is_blank(input logic [BYTE_WIDTH-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_FORMFD)
         || (c == CH_VTAB);
   endfunction

endpackage

`default_nettype wire

// ----- src/asmtok_scan.sv -----
`default_nettype none

module asmtok_scan #(
   parameter int unsigned POSITION_WIDTH = asmtok_pkg::DEFAULT_POSITION_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [asmtok_pkg::BYTE_WIDTH-1:0]    source_byte,
   input  logic                                 end_of_input,
   output asmtok_pkg::asmtok_emit_type          emit
);
   import asmtok_pkg::*;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX  = '1;
   localparam logic [POSITION_WIDTH-1:0] POS_ONE  = POSITION_WIDTH'(1);
   localparam logic [POSITION_WIDTH-1:0] POS_ZERO = '0;

   function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [POSITION_WIDTH-1:0] v);
      return FIELD_WIDTH'(v);
   endfunction

   function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   scan_mode_type               mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0]   offset_ff, offset_in;
   logic [POSITION_WIDTH-1:0]   line_ff, line_in;
   logic [POSITION_WIDTH-1:0]   column_ff, column_in;
   logic [POSITION_WIDTH-1:0]   tok_start_ff, tok_start_in;
   logic [POSITION_WIDTH-1:0]   tok_line_ff, tok_line_in;
   logic [POSITION_WIDTH-1:0]   tok_column_ff, tok_column_in;
   logic                        ended_ff, ended_in;

   logic          is_nul, is_nl, is_single;
   logic          pending_tok, can_continue, run;
   logic          comment_skip, take_cont, classify, do_flush, advance, begins_token;
   logic          new_valid;
   scan_mode_type cont_mode, class_mode;
   token_kind_type    pend_kind, single_kind;
   asmtok_result_type pend_res, new_res;

   // Byte decode
   assign is_nul = (source_byte == CH_NUL);
   assign is_nl  = (source_byte == CH_NEWLINE);

   assign pending_tok = (mode_ff == MODE_DIRECTIVE) || (mode_ff == MODE_ZERO)
                     || (mode_ff == MODE_DECIMAL) || (mode_ff == MODE_HEX)
                     || (mode_ff == MODE_IDENT);

   // Can the byte extend the pending token, and into which mode
   always_comb begin
      can_continue = 1'b0;
      cont_mode    = mode_ff;
      case (mode_ff)
         MODE_DIRECTIVE, MODE_IDENT: begin
            can_continue = is_word(source_byte);
         end
         MODE_ZERO: begin
            if ((source_byte == CH_LO_X) || (source_byte == CH_UP_X)) begin
               can_continue = 1'b1;
               cont_mode    = MODE_HEX;
            end else if (is_digit(source_byte)) begin
               can_continue = 1'b1;
               cont_mode    = MODE_DECIMAL;
            end
         end
         MODE_DECIMAL: begin
            can_continue = is_digit(source_byte);
         end
         MODE_HEX: begin
            can_continue = is_xdigit(source_byte);
         end
         default: begin
            can_continue = 1'b0;
         end
      endcase
   end

   // Mode a fresh byte starts
   always_comb begin
      if (source_byte == CH_SEMI) begin
         class_mode = MODE_COMMENT;
      end else if (source_byte == CH_DOT) begin
         class_mode = MODE_DIRECTIVE;
      end else if (source_byte == CH_ZERO) begin
         class_mode = MODE_ZERO;
      end else if (is_digit(source_byte)) begin
         class_mode = MODE_DECIMAL;
      end else if ((source_byte == CH_UNDER) || is_alpha(source_byte)) begin
         class_mode = MODE_IDENT;
      end else begin
         class_mode = MODE_IDLE;
      end
   end

   assign run          = !end_of_input && !ended_ff;
   assign comment_skip = (mode_ff == MODE_COMMENT) && !is_nl && !is_nul;
   assign take_cont    = pending_tok && can_continue;
   assign classify     = run && !comment_skip && !take_cont;
   assign do_flush     = pending_tok && !ended_ff && (end_of_input || !can_continue);
   assign advance      = run && !is_nul;
   assign begins_token = (class_mode == MODE_DIRECTIVE) || (class_mode == MODE_ZERO)
                      || (class_mode == MODE_DECIMAL) || (class_mode == MODE_IDENT);
   assign is_single    = (class_mode == MODE_IDLE) && !is_blank(source_byte) && !is_nul;

   // Next state: mode and position counters
   always_comb begin
      mode_in       = mode_ff;
      offset_in     = offset_ff;
      line_in       = line_ff;
      column_in     = column_ff;
      tok_start_in  = tok_start_ff;
      tok_line_in   = tok_line_ff;
      tok_column_in = tok_column_ff;
      ended_in      = ended_ff;
      if (end_of_input) begin
         mode_in       = MODE_IDLE;
         offset_in     = POS_ZERO;
         line_in       = POS_ONE;
         column_in     = POS_ONE;
         tok_start_in  = POS_ZERO;
         tok_line_in   = POS_ONE;
         tok_column_in = POS_ONE;
         ended_in      = 1'b0;
      end else if (!ended_ff) begin
         if (advance) begin
            offset_in = sat_inc(offset_ff);
            if (is_nl) begin
               line_in   = sat_inc(line_ff);
               column_in = POS_ONE;
            end else begin
               column_in = sat_inc(column_ff);
            end
         end
         if (take_cont) begin
            mode_in = cont_mode;
         end else if (!comment_skip) begin
            mode_in = class_mode;
            if (is_nul) begin
               ended_in = 1'b1;
            end
            if (begins_token) begin
               tok_start_in  = offset_ff;
               tok_line_in   = line_ff;
               tok_column_in = column_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         offset_ff     <= POS_ZERO;
         line_ff       <= POS_ONE;
         column_ff     <= POS_ONE;
         tok_start_ff  <= POS_ZERO;
         tok_line_ff   <= POS_ONE;
         tok_column_ff <= POS_ONE;
         ended_ff      <= 1'b0;
      end else if (step) begin
         mode_ff       <= mode_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         column_ff     <= column_in;
         tok_start_ff  <= tok_start_in;
         tok_line_ff   <= tok_line_in;
         tok_column_ff <= tok_column_in;
         ended_ff      <= ended_in;
      end
   end

   // Outputs: kind of the pending token and of a one-byte token
   always_comb begin
      case (mode_ff)
         MODE_DIRECTIVE: pend_kind = TK_DIRECTIVE;
         MODE_IDENT:     pend_kind = TK_IDENT;
         default:        pend_kind = TK_NUMBER;
      endcase
      if (is_nl) begin
         single_kind = TK_NEWLINE;
      end else if (source_byte == CH_COMMA) begin
         single_kind = TK_COMMA;
      end else if (source_byte == CH_COLON) begin
         single_kind = TK_COLON;
      end else begin
         single_kind = TK_UNKNOWN;
      end
   end

   // Outputs: assemble the results of this byte
   always_comb begin
      pend_res.token_kind   = pend_kind;
      pend_res.start_offset = to_field(tok_start_ff);
      pend_res.token_length = to_field(offset_ff - tok_start_ff);
      pend_res.token_line   = to_field(tok_line_ff);
      pend_res.token_column = to_field(tok_column_ff);
      pend_res.last_of_run  = 1'b0;

      new_valid = (end_of_input && !ended_ff) || (classify && (is_nul || is_single));

      new_res.start_offset = to_field(offset_ff);
      new_res.token_line   = to_field(line_ff);
      new_res.token_column = to_field(column_ff);
      new_res.last_of_run  = 1'b1;
      if (end_of_input || is_nul) begin
         new_res.token_kind   = TK_EOF;
         new_res.token_length = '0;
      end else begin
         new_res.token_kind   = single_kind;
         new_res.token_length = FIELD_WIDTH'(1);
      end

      emit.first_valid  = do_flush || new_valid;
      emit.second_valid = do_flush && new_valid;
      emit.second       = new_res;
      if (do_flush) begin
         emit.first             = pend_res;
         emit.first.last_of_run = !new_valid;
      end else begin
         emit.first = new_res;
      end
   end

endmodule

`default_nettype wire

// ----- src/asmtok_queue.sv -----
`default_nettype none

module asmtok_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  asmtok_pkg::asmtok_emit_type   push,
   input  logic                          push_en,
   output logic                          room,
   output logic                          out_valid,
   input  logic                          out_stall,
   output asmtok_pkg::asmtok_result_type out_data
);
   import asmtok_pkg::*;

   localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IDX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_WIDTH-1:0] ROOM_LIMIT = CNT_WIDTH'(QUEUE_DEPTH - 2);

   asmtok_result_type        slot_ff [QUEUE_DEPTH];
   asmtok_result_type        slot_in [QUEUE_DEPTH];
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic                     pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[0];
   assign pop       = out_valid && !out_stall;
   // Space for two results regardless of what drains this cycle
   assign room      = (count_ff <= ROOM_LIMIT);

   // Shift down on a transfer out, then append new results
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         count_in = count_ff - CNT_WIDTH'(1);
      end
      if (push_en && push.first_valid) begin
         slot_in[count_in[IDX_WIDTH-1:0]] = push.first;
         if (push.second_valid) begin
            slot_in[IDX_WIDTH'(count_in[IDX_WIDTH-1:0] + IDX_WIDTH'(1))] = push.second;
            count_in = count_in + CNT_WIDTH'(2);
         end else begin
            count_in = count_in + CNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/assembly_source_tokenizer.sv -----
// Path: a byte transferred in is held in the input register, scanned, and its tokens enter the
// result queue, which hands them out in order; the next result of the same byte follows the first.
// Throughput: one byte per cycle while the result queue has room; a byte that yields two tokens
// puts both into the queue at once, and the four-entry result queue absorbs such bursts.
// Reset (synchronous, active high): offset 0, line 1, column 1, idle scan mode, queue empty.
`default_nettype none

`include "assembly_source_tokenizer_macros.svh"

module assembly_source_tokenizer #(
   parameter int unsigned POSITION_WIDTH = asmtok_pkg::DEFAULT_POSITION_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [asmtok_pkg::BYTE_WIDTH-1:0]    req_source_byte,
   input  logic                                 req_end_of_input,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [asmtok_pkg::KIND_WIDTH-1:0]    rsp_token_kind,
   output logic [asmtok_pkg::FIELD_WIDTH-1:0]   rsp_start_offset,
   output logic [asmtok_pkg::FIELD_WIDTH-1:0]   rsp_token_length,
   output logic [asmtok_pkg::FIELD_WIDTH-1:0]   rsp_start_line,
   output logic [asmtok_pkg::FIELD_WIDTH-1:0]   rsp_start_column,
   output logic                                 rsp_last_of_run
);
   import asmtok_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0]  in_byte_ff;
   logic                   in_end_ff;
   logic                   accept, fire, room;
   asmtok_emit_type        emit;
   asmtok_result_type      head;

   // Input register: refills in the same cycle it hands its byte on
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_source_byte;
         in_end_ff  <= req_end_of_input;
      end
   end

   // Scanner: mode and position state, one byte per step
   asmtok_scan #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .source_byte  (in_byte_ff),
      .end_of_input (in_end_ff),
      .emit         (emit)
   );

   // Result queue
   asmtok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_en   (fire),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_token_kind   = head.token_kind;
   assign rsp_start_offset = head.start_offset;
   assign rsp_token_length = head.token_length;
   assign rsp_start_line   = head.token_line;
   assign rsp_start_column = head.token_column;
   assign rsp_last_of_run  = head.last_of_run;

   // Checks
   `ASMTOK_ASSERT_IMPLIES(a_second_needs_first, clock, reset, fire && emit.second_valid, emit.first_valid)
   `ASMTOK_ASSERT_IMPLIES(a_second_is_last, clock, reset, fire && emit.second_valid, emit.second.last_of_run && !emit.first.last_of_run)
   `ASMTOK_ASSERT_NEXT(a_input_drains, clock, reset, fire && !accept, !in_valid_ff)
   `ASMTOK_ASSERT_IMPLIES(a_eof_empty, clock, reset, rsp_valid && (rsp_token_kind == TK_EOF), (rsp_token_length == '0) && rsp_last_of_run)

endmodule

`default_nettype wire

// ----- tb/sv/assembly_source_tokenizer_test.sv -----
`default_nettype none

module assembly_source_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import asmtok_pkg::*;

   localparam logic [FIELD_WIDTH-1:0] POS_LIMIT = 16'hFFFF;
   localparam int unsigned RANDOM_ITEMS = 950;
   // receiver schedule, in its own cycles
   localparam int unsigned HOLD_FROM    = 300;
   localparam int unsigned HOLD_CYCLES  = 160;
   localparam int unsigned CALM_FROM    = 700;
   localparam int unsigned CALM_UNTIL   = 1000;

   typedef struct {
      logic [BYTE_WIDTH-1:0] source_byte;
      logic                  end_of_input;
   } source_item_type;

   typedef struct {
      logic [BYTE_WIDTH-1:0] source_byte;
      logic                  end_of_input;
      bit                    typed;
      asmtok_result_type     token;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_WIDTH-1:0]  req_source_byte = '0;
   logic                   req_end_of_input = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_WIDTH-1:0]  rsp_token_kind;
   logic [FIELD_WIDTH-1:0] rsp_start_offset;
   logic [FIELD_WIDTH-1:0] rsp_token_length;
   logic [FIELD_WIDTH-1:0] rsp_start_line;
   logic [FIELD_WIDTH-1:0] rsp_start_column;
   logic                   rsp_last_of_run;

   // sideband that travels with the payload: a hand-written expectation for this row
   bit                row_typed = 1'b0;
   asmtok_result_type row_token = '0;

   asmtok_result_type expected_tokens[$];
   directed_row_type  directed_rows[$];
   source_item_type   source_items[$];
   int unsigned       error_count  = 0;
   int unsigned       results_seen = 0;
   int unsigned       rsp_cycle    = 0;
   bit                sender_quiet = 1'b0;

   // predictor state, same reset values as the block
   scan_mode_type          lex_mode       = MODE_IDLE;
   logic [FIELD_WIDTH-1:0] pos_offset     = '0;
   logic [FIELD_WIDTH-1:0] pos_line       = 16'd1;
   logic [FIELD_WIDTH-1:0] pos_column     = 16'd1;
   logic [FIELD_WIDTH-1:0] tok_start      = '0;
   logic [FIELD_WIDTH-1:0] tok_line       = 16'd1;
   logic [FIELD_WIDTH-1:0] tok_column     = 16'd1;
   bit                     stopped_at_nul = 1'b0;
   asmtok_result_type      step_tokens[2];
   int                     step_count;

   assembly_source_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_byte  (req_source_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- byte classes
   function automatic bit char_digit(input logic [BYTE_WIDTH-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit char_letter(input logic [BYTE_WIDTH-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic bit char_hex(input logic [BYTE_WIDTH-1:0] c);
      return char_digit(c) || (c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F);
   endfunction

   function automatic bit char_word(input logic [BYTE_WIDTH-1:0] c);
      return char_letter(c) || char_digit(c) || c == CH_UNDER;
   endfunction

   function automatic bit char_blank(input logic [BYTE_WIDTH-1:0] c);
      case (c)
         CH_SPACE, CH_TAB, CH_CR, CH_FORMFD, CH_VTAB: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic logic [FIELD_WIDTH-1:0] bump(input logic [FIELD_WIDTH-1:0] v);
      return (v == POS_LIMIT) ? v : v + 16'd1;
   endfunction

   function automatic void step_position(input logic [BYTE_WIDTH-1:0] c);
      pos_offset = bump(pos_offset);
      if (c == CH_NEWLINE) begin
         pos_line   = bump(pos_line);
         pos_column = 16'd1;
      end else begin
         pos_column = bump(pos_column);
      end
   endfunction

   task automatic add_token(input token_kind_type kind, input logic [FIELD_WIDTH-1:0] start,
                            input logic [FIELD_WIDTH-1:0] len, input logic [FIELD_WIDTH-1:0] line,
                            input logic [FIELD_WIDTH-1:0] col);
      step_tokens[step_count].token_kind   = kind;
      step_tokens[step_count].start_offset = start;
      step_tokens[step_count].token_length = len;
      step_tokens[step_count].token_line   = line;
      step_tokens[step_count].token_column = col;
      step_tokens[step_count].last_of_run  = 1'b0;
      step_count++;
   endtask

   // close a pending directive, number or identifier token; its length undercounts once the offset saturates
   task automatic flush_pending();
      case (lex_mode)
         MODE_DIRECTIVE: add_token(TK_DIRECTIVE, tok_start, pos_offset - tok_start,
                                   tok_line, tok_column);
         MODE_ZERO, MODE_DECIMAL, MODE_HEX:
            add_token(TK_NUMBER, tok_start, pos_offset - tok_start, tok_line, tok_column);
         MODE_IDENT: add_token(TK_IDENT, tok_start, pos_offset - tok_start,
                               tok_line, tok_column);
         default: ;
      endcase
      lex_mode = MODE_IDLE;
   endtask

   task automatic open_token(input scan_mode_type mode, input logic [BYTE_WIDTH-1:0] c);
      tok_start  = pos_offset;
      tok_line   = pos_line;
      tok_column = pos_column;
      lex_mode   = mode;
      step_position(c);
   endtask

   function automatic bit extend_token(input logic [BYTE_WIDTH-1:0] c);
      bit taken;
      taken = 1'b0;
      case (lex_mode)
         MODE_DIRECTIVE, MODE_IDENT: taken = char_word(c);
         MODE_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
               lex_mode = MODE_HEX;
               taken    = 1'b1;
            end else if (char_digit(c)) begin
               lex_mode = MODE_DECIMAL;
               taken    = 1'b1;
            end
         end
         MODE_DECIMAL: taken = char_digit(c);
         MODE_HEX:     taken = char_hex(c);
         default:      taken = 1'b0;
      endcase
      if (taken) step_position(c);
      return taken;
   endfunction

   task automatic classify_byte(input logic [BYTE_WIDTH-1:0] c);
      token_kind_type kind;
      if (c == CH_NUL) begin
         add_token(TK_EOF, pos_offset, '0, pos_line, pos_column);
         stopped_at_nul = 1'b1;
      end else if (char_blank(c)) begin
         step_position(c);
      end else if (c == CH_SEMI) begin
         lex_mode = MODE_COMMENT;
         step_position(c);
      end else if (c == CH_DOT) begin
         open_token(MODE_DIRECTIVE, c);
      end else if (c == CH_ZERO) begin
         open_token(MODE_ZERO, c);
      end else if (char_digit(c)) begin
         open_token(MODE_DECIMAL, c);
      end else if (char_letter(c) || c == CH_UNDER) begin
         open_token(MODE_IDENT, c);
      end else begin
         case (c)
            CH_NEWLINE: kind = TK_NEWLINE;
            CH_COMMA:   kind = TK_COMMA;
            CH_COLON:   kind = TK_COLON;
            default:    kind = TK_UNKNOWN;
         endcase
         add_token(kind, pos_offset, 16'd1, pos_line, pos_column);
         step_position(c);
      end
   endtask

   // all tokens one input transfer yields, in order, into step_tokens
   task automatic tokenize_byte(input logic [BYTE_WIDTH-1:0] c, input logic at_end);
      bit consumed;
      consumed   = 1'b0;
      step_count = 0;
      if (at_end) begin
         if (!stopped_at_nul) begin
            flush_pending();
            add_token(TK_EOF, pos_offset, '0, pos_line, pos_column);
         end
         lex_mode       = MODE_IDLE;
         pos_offset     = '0;
         pos_line       = 16'd1;
         pos_column     = 16'd1;
         tok_start      = '0;
         tok_line       = 16'd1;
         tok_column     = 16'd1;
         stopped_at_nul = 1'b0;
      end else if (!stopped_at_nul) begin
         if (lex_mode == MODE_COMMENT) begin
            if (c != CH_NEWLINE && c != CH_NUL) begin
               step_position(c);
               consumed = 1'b1;
            end else begin
               lex_mode = MODE_IDLE;
            end
         end else if (lex_mode != MODE_IDLE) begin
            if (extend_token(c)) consumed = 1'b1;
            else flush_pending();
         end
         if (!consumed) classify_byte(c);
      end
      if (step_count > 0) step_tokens[step_count-1].last_of_run = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [FIELD_WIDTH-1:0] got,
                                  input logic [FIELD_WIDTH-1:0] want);
      $display("mismatch on result transfer %0d, %s: got %0d expected %0d",
               results_seen, what, got, want);
      error_count++;
   endtask

   task automatic check_token();
      asmtok_result_type want;
      results_seen++;
      if (expected_tokens.size() == 0) begin
         report_mismatch("token with none expected, kind", FIELD_WIDTH'(rsp_token_kind), '0);
         return;
      end
      want = expected_tokens.pop_front();
      if (rsp_token_kind !== want.token_kind)
         report_mismatch("token_kind", FIELD_WIDTH'(rsp_token_kind),
                         FIELD_WIDTH'(want.token_kind));
      if (rsp_start_offset !== want.start_offset)
         report_mismatch("start_offset", rsp_start_offset, want.start_offset);
      if (rsp_token_length !== want.token_length)
         report_mismatch("token_length", rsp_token_length, want.token_length);
      if (rsp_start_line !== want.token_line)
         report_mismatch("token line", rsp_start_line, want.token_line);
      if (rsp_start_column !== want.token_column)
         report_mismatch("token column", rsp_start_column, want.token_column);
      if (rsp_last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", FIELD_WIDTH'(rsp_last_of_run),
                         FIELD_WIDTH'(want.last_of_run));
   endtask

   // both channels observed at the same edge: predict on input transfers, check on output
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tokenize_byte(req_source_byte, req_end_of_input);
            if (row_typed) begin
               expected_tokens.push_back(row_token);
            end else begin
               for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tokens[i]);
            end
         end
         if (rsp_valid && !rsp_stall) check_token();
      end
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (rsp_cycle >= HOLD_FROM && rsp_cycle < HOLD_FROM + HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
         end else if (rsp_cycle >= CALM_FROM && rsp_cycle < CALM_UNTIL) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 6);
         end
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic at_end,
                            input bit typed, input asmtok_result_type tok);
      req_valid        <= 1'b1;
      req_source_byte  <= b;
      req_end_of_input <= at_end;
      row_typed        <= typed;
      row_token        <= tok;
      do @(posedge clock); while (req_stall);
      if (!sender_quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [BYTE_WIDTH-1:0] b, input logic at_end);
      directed_rows.push_back('{b, at_end, 1'b0, '0});
   endtask

   task automatic add_checked_row(input logic [BYTE_WIDTH-1:0] b, input logic at_end,
                                  input token_kind_type kind,
                                  input logic [FIELD_WIDTH-1:0] start,
                                  input logic [FIELD_WIDTH-1:0] len,
                                  input logic [FIELD_WIDTH-1:0] line,
                                  input logic [FIELD_WIDTH-1:0] col);
      asmtok_result_type tok;
      tok.token_kind   = kind;
      tok.start_offset = start;
      tok.token_length = len;
      tok.token_line   = line;
      tok.token_column = col;
      tok.last_of_run  = 1'b1;
      directed_rows.push_back('{b, at_end, 1'b1, tok});
   endtask

   // ---------------------------------------------------------------- random source text
   function automatic logic [BYTE_WIDTH-1:0] rand_letter();
      logic [BYTE_WIDTH-1:0] k;
      k = BYTE_WIDTH'($urandom_range(25));
      return ($urandom_range(1) == 0) ? CH_LO_A + k : CH_UP_A + k;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_digit();
      logic [BYTE_WIDTH-1:0] k;
      k = BYTE_WIDTH'($urandom_range(9));
      return CH_ZERO + k;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_hex_digit();
      logic [BYTE_WIDTH-1:0] k;
      k = BYTE_WIDTH'($urandom_range(21));
      if (k < 10) return CH_ZERO + k;
      if (k < 16) return CH_LO_A + k - 8'd10;
      return CH_UP_A + k - 8'd16;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_word_char();
      int unsigned v;
      v = $urandom_range(9);
      if (v < 6) return rand_letter();
      if (v < 9) return rand_digit();
      return CH_UNDER;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_blank();
      case ($urandom_range(4))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_CR;
         3: return CH_FORMFD;
         default: return CH_VTAB;
      endcase
   endfunction

   task automatic push_source(input logic [BYTE_WIDTH-1:0] b, input logic at_end);
      source_items.push_back('{b, at_end});
   endtask

   task automatic push_word_tail(input int unsigned max_len);
      repeat ($urandom_range(max_len)) push_source(rand_word_char(), 1'b0);
   endtask

   task automatic push_identifier();
      push_source(($urandom_range(7) == 0) ? CH_UNDER : rand_letter(), 1'b0);
      push_word_tail(6);
   endtask

   task automatic push_operand();
      case ($urandom_range(5))
         0: repeat ($urandom_range(1, 5)) push_source(rand_digit(), 1'b0);
         1: begin
            push_source(CH_ZERO, 1'b0);
            push_source(($urandom_range(1) == 0) ? CH_LO_X : CH_UP_X, 1'b0);
            repeat ($urandom_range(4)) push_source(rand_hex_digit(), 1'b0);
         end
         2: push_source(CH_ZERO, 1'b0);
         3: push_identifier();
         4: push_source(BYTE_WIDTH'($urandom_range(255)), 1'b0);
         default: begin
            // digits cut short by a letter that opens an identifier; a lone 0 then x or X goes hex
            repeat ($urandom_range(1, 3)) push_source(rand_digit(), 1'b0);
            push_source(rand_letter(), 1'b0);
            push_word_tail(3);
         end
      endcase
   endtask

   task automatic push_source_line(input bit with_newline);
      logic [BYTE_WIDTH-1:0] c;
      int unsigned operands;
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) push_source(rand_blank(), 1'b0);
      if ($urandom_range(99) < 25) begin
         push_identifier();
         push_source(CH_COLON, 1'b0);
         if ($urandom_range(1) == 0) push_source(rand_blank(), 1'b0);
      end
      if ($urandom_range(99) < 20) begin
         push_source(CH_DOT, 1'b0);
         push_word_tail(5);
      end else begin
         push_identifier();
      end
      operands = $urandom_range(3);
      for (int i = 0; i < operands; i++) begin
         if (i == 0) push_source(rand_blank(), 1'b0);
         else begin
            push_source(CH_COMMA, 1'b0);
            if ($urandom_range(1) == 0) push_source(rand_blank(), 1'b0);
         end
         push_operand();
      end
      if ($urandom_range(99) < 25) begin
         push_source(rand_blank(), 1'b0);
         push_source(CH_SEMI, 1'b0);
         repeat ($urandom_range(8)) begin
            c = BYTE_WIDTH'($urandom_range(1, 255));
            push_source((c == CH_NEWLINE) ? CH_SPACE : c, 1'b0);
         end
      end
      if ($urandom_range(99) < 5) push_source(BYTE_WIDTH'($urandom_range(255)), 1'b0);
      if (with_newline) push_source(CH_NEWLINE, 1'b0);
   endtask

   // one buffer: a few lines, maybe a NUL with trailing junk, then the end marker
   task automatic push_source_buffer();
      int unsigned lines;
      lines = $urandom_range(1, 4);
      for (int i = 0; i < lines; i++) push_source_line(i + 1 < lines || $urandom_range(9) < 7);
      if ($urandom_range(99) < 15) begin
         push_source(CH_NUL, 1'b0);
         repeat ($urandom_range(3)) push_source(BYTE_WIDTH'($urandom_range(255)), 1'b0);
      end
      push_source(BYTE_WIDTH'($urandom_range(255)), 1'b1);
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      source_item_type item;

      // directed table; positions start at offset 0, line 1, column 1
      add_checked_row(CH_COMMA,   1'b0, TK_COMMA,   16'd0, 16'd1, 16'd1, 16'd1);
      add_checked_row(CH_COLON,   1'b0, TK_COLON,   16'd1, 16'd1, 16'd1, 16'd2);
      add_checked_row(8'hFF,      1'b0, TK_UNKNOWN, 16'd2, 16'd1, 16'd1, 16'd3);
      add_checked_row(CH_NEWLINE, 1'b0, TK_NEWLINE, 16'd3, 16'd1, 16'd1, 16'd4);
      add_row(CH_DOT, 1'b0);
      add_row("a", 1'b0);
      add_row(CH_UNDER, 1'b0);
      add_row("9", 1'b0);
      add_row(CH_COMMA, 1'b0);           // directive ends, comma follows in one transfer
      add_row(CH_ZERO, 1'b0);
      add_row(CH_UP_X, 1'b0);
      add_row("f", 1'b0);
      add_row(CH_SPACE, 1'b0);
      add_row(CH_ZERO, 1'b0);
      add_row(CH_LO_X, 1'b0);
      add_row(CH_SEMI, 1'b0);            // bare 0x still a number, then comment
      add_row("Z", 1'b0);
      add_row(CH_NUL, 1'b0);             // NUL inside a comment
      add_row("q", 1'b0);                // ignored after NUL
      add_row(8'h41, 1'b1);              // end marker after NUL: no token
      add_row(CH_ZERO, 1'b0);
      add_row("5", 1'b0);
      add_row("k", 1'b0);                // number ends, identifier opens
      add_row(CH_NUL, 1'b0);             // NUL flushes the identifier
      add_row(8'hFF, 1'b1);
      add_checked_row(CH_NUL,     1'b1, TK_EOF,     16'd0, 16'd0, 16'd1, 16'd1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].source_byte, directed_rows[i].end_of_input,
                   directed_rows[i].typed, directed_rows[i].token);
      wait_for_drain();

      // random buffers of assembly-like text with noise
      while (source_items.size() < RANDOM_ITEMS) push_source_buffer();
      foreach (source_items[i]) begin
         item         = source_items[i];
         sender_quiet = (i >= 400 && i < 650);
         send_byte(item.source_byte, item.end_of_input, 1'b0, '0);
      end
      sender_quiet = 1'b0;
      wait_for_drain();

      // a short tail, then back-to-back end markers: the first flushes the directive, the second gives a lone EOF
      send_byte(CH_COMMA, 1'b0, 1'b0, '0);
      send_byte("a", 1'b0, 1'b0, '0);
      send_byte("b", 1'b0, 1'b0, '0);
      send_byte(CH_SPACE, 1'b0, 1'b0, '0);
      send_byte(CH_COMMA, 1'b0, 1'b0, '0);
      send_byte(CH_NEWLINE, 1'b0, 1'b0, '0);
      send_byte(CH_DOT, 1'b0, 1'b0, '0);
      send_byte("q", 1'b0, 1'b0, '0);
      send_byte(8'h80, 1'b1, 1'b0, '0);
      send_byte(8'h7F, 1'b1, 1'b0, '0);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("timeout with %0d results still expected", expected_tokens.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
